>>> src/bottom_k_hash_group_sampler_assert.svh
// ----------------------------------------------------------------------------
// Bottom-k sampler assertion macros
// Concurrent assertion wrappers clocked on clk; compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef BOTTOM_K_HASH_GROUP_SAMPLER_ASSERT_SVH
`define BOTTOM_K_HASH_GROUP_SAMPLER_ASSERT_SVH

`ifndef ASSERT_OFF
// check outside reset
`define BKHS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// check at every edge, reset included
`define BKHS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BKHS_ASSERT(lbl, prop, msg)
`define BKHS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> src/bkhs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bottom-k sampler package
// Field widths, hash constants, result codes, sequencer states and defaults.
// ----------------------------------------------------------------------------
package bkhs_pkg;

	localparam int OP_W     = 1;
	localparam int GROUP_W  = 10;
	localparam int ID_W     = 32;
	localparam int SLOT_W   = 4;
	localparam int STATUS_W = 3;
	localparam int FILL_W   = 5;
	localparam int KEEP_W   = 5;

	localparam int DEF_NUM_GROUPS = 1024;
	localparam int DEF_MAX_KEEP   = 16;

	localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd8;

	localparam logic [ID_W-1:0] HASH_MUL1 = 32'h7feb352d;
	localparam logic [ID_W-1:0] HASH_MUL2 = 32'h846ca68b;

	localparam logic [OP_W-1:0] OP_INSERT = 1'b0;
	localparam logic [OP_W-1:0] OP_READ   = 1'b1;

	localparam logic [STATUS_W-1:0] ST_APPEND     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_REPLACE    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_REJECT     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_READ_OK    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_READ_EMPTY = 3'd4;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_FILL,
		S_READ,
		S_HASH2,
		S_SCAN1,
		S_SCAN2,
		S_LAST,
		S_DECIDE
	} state_t;

	// control of the shared hash multiplier
	typedef struct packed {
		logic en;      // load the product register
		logic second;  // second round: mix the product, multiply by HASH_MUL2
	} hash_ctl_t;

endpackage

>>> src/bkhs_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bottom-k sampler request channel
// Valid/ready channel carrying one insert or read word.
// ----------------------------------------------------------------------------
interface bkhs_req_if
	import bkhs_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     op;
	logic [GROUP_W-1:0]  group;
	logic [ID_W-1:0]     unit_id;
	logic [SLOT_W-1:0]   read_slot;

	modport source (output valid, op, group, unit_id, read_slot, input ready);
	modport sink (input valid, op, group, unit_id, read_slot, output ready);
endinterface

>>> src/bkhs_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bottom-k sampler response channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface bkhs_rsp_if
	import bkhs_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot;
	logic [ID_W-1:0]     id_out;
	logic [FILL_W-1:0]   group_fill;

	modport source (output valid, status, slot, id_out, group_fill, input ready);
	modport sink (input valid, status, slot, id_out, group_fill, output ready);
endinterface

>>> src/bkhs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bottom-k sampler RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bkhs_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> src/bkhs_hash_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bottom-k sampler hash unit
// One 32x32 multiplier shared by both rounds of the mixing finalizer.
// ----------------------------------------------------------------------------
module bkhs_hash_unit
	import bkhs_pkg::*;
(
	input  logic            clk,
	input  hash_ctl_t       ctl,
	input  logic [ID_W-1:0] x,
	output logic [ID_W-1:0] hash
);

	logic [ID_W-1:0] prod_q;
	logic [ID_W-1:0] opa;
	logic [ID_W-1:0] opb;

	always_comb begin
		if (ctl.second) begin
			opa = prod_q ^ (prod_q >> 15);
			opb = HASH_MUL2;
		end else begin
			opa = x ^ (x >> 16);
			opb = HASH_MUL1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			prod_q <= ID_W'(opa * opb);
		end
	end

	assign hash = prod_q ^ (prod_q >> 16);

endmodule

>>> src/bottom_k_hash_group_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bottom-k hash group sampler
// Per-group sample of the ids with the lowest 32-bit mixing hash.
// ----------------------------------------------------------------------------
// Each group keeps up to min(keep_count, MAX_KEEP) ids. An insert appends while
// the group has room; once full, the stored id with the greatest hash (first on
// ties) is evicted when the new id hashes strictly lower, otherwise the id is
// rejected. A read returns one stored id and the group fill. One word is taken
// at a time. An insert into a full group hashes the new id and every stored id
// of the group on the single shared multiplier, which needs two passes per hash.
// A result that cannot enter the output register holds the sequencer in its
// result state while rsp stalls. After reset the block sweeps the fill counters
// to zero, one group per cycle, before it takes the first word; keep_count
// writes are taken at any time. Results sit in an output register, so a
// finished word may wait on rsp while the next request is already accepted.
module bottom_k_hash_group_sampler
	import bkhs_pkg::*;
#(
	parameter int NUM_GROUPS = DEF_NUM_GROUPS,
	parameter int MAX_KEEP   = DEF_MAX_KEEP
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [KEEP_W-1:0] cfg_wr_data,
	bkhs_req_if.sink          req,
	bkhs_rsp_if.source        rsp
);

	`include "bottom_k_hash_group_sampler_assert.svh"

	localparam int GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
	localparam int AW = (NUM_GROUPS * MAX_KEEP > 1) ? $clog2(NUM_GROUPS * MAX_KEEP) : 1;
	localparam int FW = $clog2(MAX_KEEP + 1);
	localparam int CW = (FW > KEEP_W) ? FW + 1 : KEEP_W + 1;

	// configuration
	logic [KEEP_W-1:0] keep_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_count_q <= KEEP_RESET;
		end else if (cfg_wr_en) begin
			keep_count_q <= cfg_wr_data;
		end
	end

	// sequencer state and counters
	state_t state_q, state_d;
	logic [GW-1:0] clr_idx_q;

	// request held for the duration of the item
	logic [OP_W-1:0]   op_q;
	logic              grp_ok_q;
	logic [GW-1:0]     grp_q;
	logic [ID_W-1:0]   id_q;
	logic [SLOT_W-1:0] rslot_q;
	logic [AW-1:0]     base_q;

	// scan bookkeeping
	logic [FW-1:0]   fill_q;
	logic [FW-1:0]   scan_idx_q;
	logic [FW-1:0]   cur_idx_q;
	logic [ID_W-1:0] cur_id_q;
	logic            first_q;
	logic [ID_W-1:0] new_hash_q;
	logic [ID_W-1:0] worst_h_q;
	logic [FW-1:0]   worst_idx_q;
	logic [ID_W-1:0] worst_id_q;

	// memories and hash unit
	logic            fill_we, fill_re;
	logic [GW-1:0]   fill_waddr, fill_raddr;
	logic [FW-1:0]   fill_wdata, fill_rd;
	logic            id_we, id_re;
	logic [AW-1:0]   id_waddr, id_raddr;
	logic [ID_W-1:0] id_rd;
	hash_ctl_t       hash_ctl;
	logic [ID_W-1:0] hash_x, hash_out;

	// result
	logic                res_valid, res_fire;
	logic [STATUS_W-1:0] res_status;
	logic [SLOT_W-1:0]   res_slot;
	logic [ID_W-1:0]     res_id;
	logic [FILL_W-1:0]   res_fill;
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic [ID_W-1:0]     out_id_q;
	logic [FILL_W-1:0]   out_fill_q;

	// helpers
	logic [GW-1:0]   req_grp;
	logic [CW-1:0]   limit;
	logic [FW:0]     next_idx;
	logic            take_worst;

	assign req_grp  = GW'(req.group);
	assign limit    = (CW'(keep_count_q) < CW'(MAX_KEEP)) ? CW'(keep_count_q) : CW'(MAX_KEEP);
	assign next_idx = (FW + 1)'(scan_idx_q) + 1'b1;
	// first scanned hash always seeds the maximum; later ones only on strictly greater
	assign take_worst = (cur_idx_q == '0) || (hash_out > worst_h_q);
	// load the output register when it is empty or being drained
	assign res_fire = res_valid && (!out_valid_q || rsp.ready);

	bkhs_ram #(
		.DEPTH (NUM_GROUPS),
		.WIDTH (FW),
		.AW    (GW)
	) u_fill_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (fill_waddr),
		.wdata (fill_wdata),
		.re    (fill_re),
		.raddr (fill_raddr),
		.rdata (fill_rd)
	);

	bkhs_ram #(
		.DEPTH (NUM_GROUPS * MAX_KEEP),
		.WIDTH (ID_W),
		.AW    (AW)
	) u_id_ram (
		.clk   (clk),
		.we    (id_we),
		.waddr (id_waddr),
		.wdata (id_q),
		.re    (id_re),
		.raddr (id_raddr),
		.rdata (id_rd)
	);

	bkhs_hash_unit u_hash (
		.clk  (clk),
		.ctl  (hash_ctl),
		.x    (hash_x),
		.hash (hash_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, memory and hash control, result selection
	always_comb begin
		state_d    = state_q;
		req.ready  = 1'b0;
		fill_we    = 1'b0;
		fill_waddr = grp_q;
		fill_wdata = '0;
		fill_re    = 1'b0;
		fill_raddr = req_grp;
		id_we      = 1'b0;
		id_waddr   = base_q + AW'(fill_rd);
		id_re      = 1'b0;
		id_raddr   = base_q;
		hash_ctl   = '0;
		hash_x     = id_q;
		res_valid  = 1'b0;
		res_status = ST_REJECT;
		res_slot   = '0;
		res_id     = '0;
		res_fill   = '0;

		case (state_q)
			S_CLEAR: begin
				fill_we    = 1'b1;
				fill_waddr = clr_idx_q;
				if (clr_idx_q == GW'(NUM_GROUPS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req.ready = 1'b1;
				fill_re   = 1'b1;
				if (req.valid) begin
					state_d = S_FILL;
				end
			end
			S_FILL: begin
				if (!grp_ok_q) begin
					// group out of range: nothing stored, fill reads as zero
					res_valid  = 1'b1;
					res_status = (op_q == OP_READ) ? ST_READ_EMPTY : ST_REJECT;
					res_slot   = (op_q == OP_READ) ? rslot_q : '0;
				end else if (op_q == OP_READ) begin
					if (CW'(rslot_q) < CW'(fill_rd)) begin
						id_re    = 1'b1;
						id_raddr = base_q + AW'(rslot_q);
						state_d  = S_READ;
					end else begin
						res_valid  = 1'b1;
						res_status = ST_READ_EMPTY;
						res_slot   = rslot_q;
						res_fill   = FILL_W'(fill_rd);
					end
				end else if (CW'(fill_rd) < limit) begin
					res_valid  = 1'b1;
					res_status = ST_APPEND;
					res_slot   = SLOT_W'(fill_rd);
					res_fill   = FILL_W'(fill_rd + 1'b1);
					id_we      = res_fire;
					fill_we    = res_fire;
					fill_wdata = FW'(fill_rd + 1'b1);
				end else if (fill_rd == '0) begin
					// zero limit on an empty group: nothing to replace
					res_valid = 1'b1;
				end else begin
					// first round of the new id's hash, fetch stored id 0
					hash_ctl.en = 1'b1;
					id_re       = 1'b1;
					state_d     = S_HASH2;
				end
				if (res_fire) begin
					state_d = S_IDLE;
				end
			end
			S_READ: begin
				res_valid  = 1'b1;
				res_status = ST_READ_OK;
				res_slot   = rslot_q;
				res_id     = id_rd;
				res_fill   = FILL_W'(fill_q);
				if (res_fire) begin
					state_d = S_IDLE;
				end
			end
			S_HASH2: begin
				hash_ctl = '{en: 1'b1, second: 1'b1};
				state_d  = S_SCAN1;
			end
			S_SCAN1: begin
				// start the next stored id, prefetch the one after it
				hash_ctl.en = 1'b1;
				hash_x      = id_rd;
				if (next_idx < (FW + 1)'(fill_q)) begin
					id_re    = 1'b1;
					id_raddr = base_q + AW'(next_idx);
				end
				state_d = S_SCAN2;
			end
			S_SCAN2: begin
				hash_ctl = '{en: 1'b1, second: 1'b1};
				state_d  = (scan_idx_q == fill_q) ? S_LAST : S_SCAN1;
			end
			S_LAST: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				res_valid = 1'b1;
				res_fill  = FILL_W'(fill_q);
				if (new_hash_q < worst_h_q) begin
					res_status = ST_REPLACE;
					res_slot   = SLOT_W'(worst_idx_q);
					res_id     = worst_id_q;
					id_we      = res_fire;
					id_waddr   = base_q + AW'(worst_idx_q);
				end
				if (res_fire) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// clearing sweep over the fill counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (state_q == S_CLEAR) begin
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q     <= req.op;
				grp_ok_q <= 32'(req.group) < 32'(NUM_GROUPS);
				grp_q    <= req_grp;
				id_q     <= req.unit_id;
				rslot_q  <= req.read_slot;
				base_q   <= AW'(req_grp) * AW'(MAX_KEEP);
			end
			S_FILL: begin
				fill_q     <= fill_rd;
				scan_idx_q <= '0;
				first_q    <= 1'b1;
			end
			S_SCAN1: begin
				if (first_q) begin
					new_hash_q <= hash_out;
				end else if (take_worst) begin
					worst_h_q   <= hash_out;
					worst_idx_q <= cur_idx_q;
					worst_id_q  <= cur_id_q;
				end
				first_q    <= 1'b0;
				cur_id_q   <= id_rd;
				cur_idx_q  <= scan_idx_q;
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			S_LAST: begin
				if (take_worst) begin
					worst_h_q   <= hash_out;
					worst_idx_q <= cur_idx_q;
					worst_id_q  <= cur_id_q;
				end
			end
			default: begin
			end
		endcase
	end

	// output register: hold the word until rsp takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_fire) begin
			out_status_q <= res_status;
			out_slot_q   <= res_slot;
			out_id_q     <= res_id;
			out_fill_q   <= res_fill;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.slot       = out_slot_q;
	assign rsp.id_out     = out_id_q;
	assign rsp.group_fill = out_fill_q;

	// one word in flight: the block goes busy right after taking a request
	`BKHS_ASSERT(a_busy_after_accept, (req.valid && req.ready) |=> !req.ready, "request taken while busy")
	// a read hit always points below the group fill
	`BKHS_ASSERT(a_read_ok_in_fill, (rsp.valid && rsp.status == ST_READ_OK) |-> (FILL_W'(rsp.slot) < rsp.group_fill), "read hit beyond fill")
	// append and replace only ever leave a non-empty group
	`BKHS_ASSERT(a_store_nonempty, (rsp.valid && (rsp.status == ST_APPEND || rsp.status == ST_REPLACE)) |-> (rsp.group_fill != '0), "store with empty group")
	// hold the request side off while reset is applied
	`BKHS_ASSERT_ALWAYS(a_quiet_in_reset, !arst_n |-> !req.ready, "ready raised in reset")

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bottom-k hash group sampler testbench
// Sends insert and read words to the sampler, rebuilds every group's sample
// beside the block, and compares each result word field by field.
// ----------------------------------------------------------------------------
module testbench;
	import bkhs_pkg::*;

	// one request word as the sender holds it
	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [GROUP_W-1:0] group;
		logic [ID_W-1:0]    unit_id;
		logic [SLOT_W-1:0]  read_slot;
	} sampler_word_t;

	// one result word, in the order of the response fields
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic [ID_W-1:0]     id_out;
		logic [FILL_W-1:0]   group_fill;
	} sample_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// all block inputs come from these registers, so they are known from time 0
	logic                drv_valid     = 1'b0;
	sampler_word_t       drv_word      = '0;
	logic                drv_rsp_ready = 1'b0;
	logic                cfg_wr_en     = 1'b0;
	logic [KEEP_W-1:0]   cfg_wr_data   = '0;

	bkhs_req_if req_ch ();
	bkhs_rsp_if rsp_ch ();

	assign req_ch.valid     = drv_valid;
	assign req_ch.op        = drv_word.op;
	assign req_ch.group     = drv_word.group;
	assign req_ch.unit_id   = drv_word.unit_id;
	assign req_ch.read_slot = drv_word.read_slot;
	assign rsp_ch.ready     = drv_rsp_ready;

	bottom_k_hash_group_sampler dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req_ch),
		.rsp         (rsp_ch)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------------
	// Shadow copy of the sampler state
	// ------------------------------------------------------------------------
	logic [ID_W-1:0]   kept_shadow [DEF_NUM_GROUPS][DEF_MAX_KEEP];
	int                fill_shadow [DEF_NUM_GROUPS];
	logic [KEEP_W-1:0] keep_setting = KEEP_RESET;

	sampler_word_t  pending_words [$];
	sample_result_t expected_results [$];

	int  mismatches   = 0;
	int  words_sent   = 0;
	int  inserts_sent = 0;
	int  keep_writes  = 0;
	int  status_seen [8];
	bit  no_idle      = 1'b0;
	bit  hold_go      = 1'b0;
	logic hold_rsp    = 1'b0;

	// xor-shift / multiply finalizer over 32 bits
	function automatic logic [ID_W-1:0] mix32(logic [ID_W-1:0] x);
		x = x ^ (x >> 16);
		x = x * HASH_MUL1;
		x = x ^ (x >> 15);
		x = x * HASH_MUL2;
		x = x ^ (x >> 16);
		return x;
	endfunction

	// Apply one accepted word to the shadow sample and return its result.
	// The group field is 10 bits wide, so every group index is in range.
	function automatic sample_result_t apply_to_sample(sampler_word_t w);
		sample_result_t r;
		int fill;
		int limit;
		int worst;
		logic [ID_W-1:0] worst_h;
		logic [ID_W-1:0] h;
		r = '0;
		fill = fill_shadow[w.group];
		if (w.op == OP_READ) begin
			r.slot = w.read_slot;
			r.group_fill = FILL_W'(fill);
			if (int'(w.read_slot) < fill) begin
				r.status = ST_READ_OK;
				r.id_out = kept_shadow[w.group][w.read_slot];
			end else begin
				r.status = ST_READ_EMPTY;
			end
			return r;
		end
		// keep_count above the array depth saturates
		limit = (int'(keep_setting) < DEF_MAX_KEEP) ? int'(keep_setting) : DEF_MAX_KEEP;
		if (fill < limit) begin
			kept_shadow[w.group][fill] = w.unit_id;
			fill_shadow[w.group] = fill + 1;
			r.status = ST_APPEND;
			r.slot = SLOT_W'(fill);
			r.group_fill = FILL_W'(fill + 1);
			return r;
		end
		// zero limit on an empty group: nothing to replace
		if (fill == 0) begin
			r.status = ST_REJECT;
			return r;
		end
		// scan every current entry, also when the limit was lowered under the fill
		worst = 0;
		worst_h = mix32(kept_shadow[w.group][0]);
		for (int q = 1; q < fill; q++) begin
			h = mix32(kept_shadow[w.group][q]);
			if (h > worst_h) begin
				worst_h = h;
				worst = q;
			end
		end
		r.group_fill = FILL_W'(fill);
		if (mix32(w.unit_id) < worst_h) begin
			r.status = ST_REPLACE;
			r.slot = SLOT_W'(worst);
			r.id_out = kept_shadow[w.group][worst];
			kept_shadow[w.group][worst] = w.unit_id;
		end else begin
			r.status = ST_REJECT;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Request driver: predict on acceptance, then present the next word
	// ------------------------------------------------------------------------
	int            send_gap = 0;
	sampler_word_t next_word;

	always @(posedge clk) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				expected_results.push_back(apply_to_sample(drv_word));
				words_sent++;
				if (drv_word.op == OP_INSERT)
					inserts_sent++;
			end
			// hold the word until it is taken
			if (!req_ch.valid || req_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					drv_valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					next_word = pending_words.pop_front();
					drv_valid <= 1'b1;
					drv_word <= next_word;
					// idle burst after this word is taken
					if (!no_idle && $urandom_range(0, 7) == 0)
						send_gap = $urandom_range(1, 4);
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Response monitor: stall at random, compare against the oldest prediction
	// ------------------------------------------------------------------------
	int             recv_gap = 0;
	sample_result_t got;
	sample_result_t want;
	bit             bad;

	always @(posedge clk) begin
		if (!arst_n) begin
			drv_rsp_ready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (hold_rsp) begin
				drv_rsp_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				drv_rsp_ready <= 1'b0;
			end else begin
				drv_rsp_ready <= 1'b1;
				if (!no_idle && $urandom_range(0, 5) == 0)
					recv_gap = $urandom_range(1, 4);
			end

			if (rsp_ch.valid && rsp_ch.ready) begin
				got.status = rsp_ch.status;
				got.slot = rsp_ch.slot;
				got.id_out = rsp_ch.id_out;
				got.group_fill = rsp_ch.group_fill;
				status_seen[got.status]++;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result word with nothing pending: status %0d slot %0d id %h fill %0d",
							$realtime, got.status, got.slot, got.id_out, got.group_fill);
				end else begin
					want = expected_results.pop_front();
					bad = 1'b0;
					if (got.status !== want.status)
						bad = 1'b1;
					if (got.slot !== want.slot)
						bad = 1'b1;
					if (got.id_out !== want.id_out)
						bad = 1'b1;
					if (got.group_fill !== want.group_fill)
						bad = 1'b1;
					if (bad) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: mismatch: status %0d/%0d slot %0d/%0d id %h/%h fill %0d/%0d (expected/actual)",
								$realtime, want.status, got.status, want.slot, got.slot,
								want.id_out, got.id_out, want.group_fill, got.group_fill);
					end
				end
			end
		end
	end

	// long receiver hold-off, so the output register fills and req stalls
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_rsp <= 1'b1;
		repeat (300) @(posedge clk);
		hold_rsp <= 1'b0;
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	task automatic push_insert(logic [GROUP_W-1:0] g, logic [ID_W-1:0] id);
		sampler_word_t w;
		w = '0;
		w.op = OP_INSERT;
		w.group = g;
		w.unit_id = id;
		w.read_slot = SLOT_W'($urandom);  // ignored on insert
		pending_words.push_back(w);
	endtask

	task automatic push_read(logic [GROUP_W-1:0] g, logic [SLOT_W-1:0] s);
		sampler_word_t w;
		w = '0;
		w.op = OP_READ;
		w.group = g;
		w.unit_id = $urandom;  // ignored on read
		w.read_slot = s;
		pending_words.push_back(w);
	endtask

	// advance until every word is sent and every result has come back
	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_words.size() != 0 || drv_valid || expected_results.size() != 0);
	endtask

	task automatic set_keep(logic [KEEP_W-1:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		keep_setting = v;
		keep_writes++;
	endtask

	function automatic logic [ID_W-1:0] pick_id();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return ID_W'($urandom_range(0, 15));
			default: return $urandom;
		endcase
	endfunction

	// Mostly inserts into a small set of hot groups, so groups fill up and
	// the replacement scan runs; the rest is reads and scattered traffic.
	task automatic fill_random_phase(int n);
		logic [GROUP_W-1:0] hot [8];
		int r;
		for (int i = 0; i < 8; i++)
			hot[i] = GROUP_W'($urandom_range(0, DEF_NUM_GROUPS - 1));
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				push_insert(hot[$urandom_range(0, 7)], pick_id());
			else if (r < 88)
				push_read(hot[$urandom_range(0, 7)], SLOT_W'($urandom_range(0, 15)));
			else if (r < 94)
				push_insert(GROUP_W'($urandom), pick_id());
			else
				push_read(GROUP_W'($urandom), SLOT_W'($urandom));
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	logic [KEEP_W-1:0] phase_keep [7] = '{5'd16, 5'd3, 5'd31, 5'd0, 5'd1, 5'd12, 5'd8};

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset value of keep_count (8): empty reads, fill a group, then overflow it
		push_read(10'd0, 4'd0);
		push_read(10'd1023, 4'd15);
		push_insert(10'd5, 32'h0000_0000);
		push_insert(10'd5, 32'hffff_ffff);
		for (int i = 0; i < 8; i++)
			push_insert(10'd5, $urandom);
		push_read(10'd5, 4'd7);
		push_read(10'd5, 4'd8);
		push_insert(10'd1023, 32'hffff_ffff);
		push_read(10'd1023, 4'd0);
		wait_drained();

		// zero limit: empty group rejects, full group scans all its entries
		set_keep(5'd0);
		push_insert(10'd9, $urandom);
		push_insert(10'd5, $urandom);
		wait_drained();

		// limit lowered under the fill, and a group whose only hash is zero
		set_keep(5'd1);
		push_insert(10'd12, 32'h0000_0000);
		push_insert(10'd12, 32'h0001_2345);
		push_insert(10'd12, 32'h0000_0000);
		push_insert(10'd5, $urandom);
		push_read(10'd5, 4'd3);
		wait_drained();

		// limit above the array depth saturates, so the group grows again
		set_keep(5'd31);
		push_insert(10'd5, $urandom);
		push_insert(10'd5, $urandom);
		push_read(10'd5, 4'd9);
		wait_drained();

		// random phases across several limits; the last one runs without idling
		foreach (phase_keep[p]) begin
			set_keep(phase_keep[p]);
			if (p == 1)
				hold_go = 1'b1;
			if (p == 6)
				no_idle = 1'b1;
			fill_random_phase(215);
			wait_drained();
		end

		// drain the pipeline once more before the verdict
		repeat (60) @(posedge clk);

		if (expected_results.size() != 0)
			$display("%0d predicted results never arrived", expected_results.size());
		$display("Covered %0d words (%0d inserts, %0d reads) over %0d keep_count writes",
			words_sent, inserts_sent, words_sent - inserts_sent, keep_writes);
		$display("Results seen: %0d appended, %0d replaced, %0d rejected, %0d read ok, %0d read empty",
			status_seen[ST_APPEND], status_seen[ST_REPLACE], status_seen[ST_REJECT],
			status_seen[ST_READ_OK], status_seen[ST_READ_EMPTY]);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatched result words", mismatches);
			$display("TEST FAILED");
		end
		$finish;
	end

	// watchdog: far above the slowest legal run
	initial begin
		#4_000_000;
		$display("timeout with %0d words pending and %0d results outstanding",
			pending_words.size(), expected_results.size());
		$display("TEST FAILED");
		$finish;
	end

endmodule
